FILE: rtl/jhs_pkg.sv
// ============================================================================
// jhs_pkg: shared types and constants for the heat stencil block
// Grid geometry, command codes and the controller/datapath interface structs.
// ============================================================================
package jhs_pkg;

    localparam int GRID_MAX = 64;
    localparam int IDX_W    = $clog2(GRID_MAX);
    localparam int CELLS    = GRID_MAX * GRID_MAX;
    localparam int LEN_W    = 7;
    localparam int TEMP_W   = 16;
    localparam int SWEEP_W  = 16;
    localparam int ACC_W    = TEMP_W + 2;

    // Register byte addresses on the config port
    localparam logic [3:0] REG_ROOM_LENGTH  = 4'h0;
    localparam logic [3:0] REG_AMBIENT_TEMP = 4'h4;
    localparam logic [3:0] REG_HEARTH_TEMP  = 4'h8;

    typedef enum logic [1:0] {
        OP_INIT  = 2'd0,
        OP_WRITE = 2'd1,
        OP_READ  = 2'd2,
        OP_SWEEP = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        A_CMD,
        A_CNT,
        A_NORTH,
        A_SOUTH,
        A_WEST,
        A_EAST
    } t_addr_sel;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_RDWAIT,
        S_INIT,
        S_CELL,
        S_RD_S,
        S_RD_W,
        S_RD_E,
        S_WB,
        S_WB_C,
        S_SWAP,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [LEN_W-1:0]  room_length;
        logic [TEMP_W-1:0] ambient_temp;
        logic [TEMP_W-1:0] hearth_temp;
    } t_cfg;

    typedef struct packed {
        logic      load;
        logic      cnt_clr;
        logic      cnt_adv_full;
        logic      cnt_adv_len;
        t_addr_sel addr_sel;
        logic      wr_both;
        logic      wr_init;
        logic      wr_dst_avg;
        logic      wr_dst_copy;
        logic      acc_load;
        logic      acc_add;
        logic      set_oor;
        logic      cap_rd;
        logic      swap;
        logic      clr_cur;
    } t_dp_cmd;

    typedef struct packed {
        t_op  op;
        logic oor;
        logic sweeps_zero;
        logic sweeps_last;
        logic len_zero;
        logic border;
        logic last_cell;
        logic last_full;
    } t_dp_status;

endpackage

FILE: rtl/jacobi_heat_stencil_2d.sv
// ============================================================================
// jacobi_heat_stencil_2d: 2D five-point Jacobi heat grid
// Config registers, command sequencer and grid datapath.
// ============================================================================
// Usage:
//   An item is a command on i_operation with i_row/i_col/i_cell_value/
//   i_sweep_count. It is taken at a clock edge with start high and busy low.
//   Each item gives one result, shown for one cycle with o_valid high:
//   o_read_value, o_out_of_range and o_op_done. The receiver cannot stall.
//   A read goes through the registered store read. Initialize does one
//   store write per cell, to both stores at once. A sweep makes N passes
//   over the grid; an interior cell reads its four neighbors one at a time
//   through the single read port of the store.
//   The next item can be taken the cycle after the result.
//   Config is written over the APB port by the user, who must do so only
//   while the block is idle; the block itself does not enforce it:
//     0x0 room_length, 0x4 ambient_temp, 0x8 hearth_temp.
//   Reset (i_rst_n low, synchronous) restores register defaults and makes
//   the first store current; the grid contents stay undefined until an
//   initialize or a write.
// ============================================================================
module jacobi_heat_stencil_2d
    import jhs_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         i_operation,
    input  logic [IDX_W-1:0]   i_row,
    input  logic [IDX_W-1:0]   i_col,
    input  logic [TEMP_W-1:0]  i_cell_value,
    input  logic [SWEEP_W-1:0] i_sweep_count,
    output logic               o_valid,
    output logic [TEMP_W-1:0]  o_read_value,
    output logic               o_out_of_range,
    output logic               o_op_done,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    t_cfg       r_cfg;
    t_dp_cmd    cmd;
    t_dp_status status;
    logic       done;
    logic       cfg_wr;
    logic [TEMP_W-1:0] rd_value;
    logic              oor;

    // Config registers
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.room_length  <= LEN_W'(64);
            r_cfg.ambient_temp <= TEMP_W'(5120);
            r_cfg.hearth_temp  <= TEMP_W'(25600);
        end else if (cfg_wr) begin
            unique case (paddr)
                REG_ROOM_LENGTH:  r_cfg.room_length  <= pwdata[LEN_W-1:0];
                REG_AMBIENT_TEMP: r_cfg.ambient_temp <= pwdata[TEMP_W-1:0];
                REG_HEARTH_TEMP:  r_cfg.hearth_temp  <= pwdata[TEMP_W-1:0];
                default: ;
            endcase
        end
    end

    // Readback
    always_comb begin
        unique case (paddr)
            REG_ROOM_LENGTH:  prdata = 32'(r_cfg.room_length);
            REG_AMBIENT_TEMP: prdata = 32'(r_cfg.ambient_temp);
            REG_HEARTH_TEMP:  prdata = 32'(r_cfg.hearth_temp);
            default:          prdata = '0;
        endcase
    end

    jhs_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (busy),
        .o_done   (done)
    );

    jhs_datapath u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_operation    (i_operation),
        .i_row          (i_row),
        .i_col          (i_col),
        .i_cell_value   (i_cell_value),
        .i_sweep_count  (i_sweep_count),
        .i_cmd          (cmd),
        .o_status       (status),
        .o_read_value   (rd_value),
        .o_out_of_range (oor)
    );

    // Result strobe
    assign o_valid        = done;
    assign o_op_done      = done;
    assign o_read_value   = rd_value;
    assign o_out_of_range = oor;

endmodule

FILE: rtl/jhs_ram.sv
// ============================================================================
// jhs_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered.
// ============================================================================
module jhs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/jhs_datapath.sv
// ============================================================================
// jhs_datapath: grid stores, cell counters and stencil accumulator
// Holds the two ping-pong stores and does what the controller commands.
// ============================================================================
module jhs_datapath
    import jhs_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cfg               i_cfg,
    input  logic [1:0]         i_operation,
    input  logic [IDX_W-1:0]   i_row,
    input  logic [IDX_W-1:0]   i_col,
    input  logic [TEMP_W-1:0]  i_cell_value,
    input  logic [SWEEP_W-1:0] i_sweep_count,
    input  t_dp_cmd            i_cmd,
    output t_dp_status         o_status,
    output logic [TEMP_W-1:0]  o_read_value,
    output logic               o_out_of_range
);

    localparam int ADDR_W = 2 * IDX_W;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(GRID_MAX - 1);

    // Latched command
    t_op                r_op;
    logic [IDX_W-1:0]   r_crow, r_ccol;
    logic [TEMP_W-1:0]  r_cval;
    logic [SWEEP_W-1:0] r_sweeps;
    // Walk counters, accumulator, result registers, store select
    logic [IDX_W-1:0]   r_row, r_col;
    logic [ACC_W-1:0]   r_acc;
    logic [TEMP_W-1:0]  r_rd;
    logic               r_oor;
    logic               r_cur;

    logic [LEN_W-1:0]  len;
    logic [IDX_W-1:0]  len_m1;
    logic [15:0]       span_prod;
    logic [IDX_W-1:0]  span;
    logic              hearth;
    logic [ACC_W-1:0]  sum;
    logic [TEMP_W-1:0] rd_first, rd_second, src_data;
    logic [ADDR_W-1:0] raddr, waddr;
    logic [TEMP_W-1:0] wdata;
    logic              we_first, we_second, wr_dst;

    // Effective length and hearth span start, ceil(0.4*L) = (2L+4)/5
    assign len       = (i_cfg.room_length > LEN_W'(GRID_MAX)) ? LEN_W'(GRID_MAX)
                                                              : i_cfg.room_length;
    assign len_m1    = IDX_W'(len - LEN_W'(1));
    assign span_prod = (16'({len, 1'b0}) + 16'd4) * 16'd205;
    assign span      = span_prod[15:10];
    assign hearth    = (r_row == '0) && (r_col >= span)
                       && ((LEN_W'(r_col) + LEN_W'(span)) < len);

    // Status toward the controller
    always_comb begin
        o_status.op          = r_op;
        o_status.oor         = (LEN_W'(r_crow) >= len) || (LEN_W'(r_ccol) >= len);
        o_status.sweeps_zero = (r_sweeps == '0);
        o_status.sweeps_last = (r_sweeps == SWEEP_W'(1));
        o_status.len_zero    = (len == '0);
        o_status.border      = (r_row == '0) || (r_col == '0)
                               || ((LEN_W'(r_row) + LEN_W'(1)) >= len)
                               || ((LEN_W'(r_col) + LEN_W'(1)) >= len);
        o_status.last_cell   = (r_row == len_m1) && (r_col == len_m1);
        o_status.last_full   = (r_row == IDX_LAST) && (r_col == IDX_LAST);
    end

    // Read address select
    always_comb begin
        case (i_cmd.addr_sel)
            A_CMD:   raddr = {r_crow, r_ccol};
            A_NORTH: raddr = {r_row - IDX_W'(1), r_col};
            A_SOUTH: raddr = {r_row + IDX_W'(1), r_col};
            A_WEST:  raddr = {r_row, r_col - IDX_W'(1)};
            A_EAST:  raddr = {r_row, r_col + IDX_W'(1)};
            default: raddr = {r_row, r_col};
        endcase
    end

    assign src_data = r_cur ? rd_second : rd_first;
    assign sum      = r_acc + ACC_W'(src_data);

    // Write port: command writes and init go to both stores, sweeps to the next one
    assign wr_dst    = i_cmd.wr_dst_avg | i_cmd.wr_dst_copy;
    assign we_first  = i_cmd.wr_both | i_cmd.wr_init | (wr_dst & r_cur);
    assign we_second = i_cmd.wr_both | i_cmd.wr_init | (wr_dst & ~r_cur);
    assign waddr     = i_cmd.wr_both ? {r_crow, r_ccol} : {r_row, r_col};

    always_comb begin
        if (i_cmd.wr_both) begin
            wdata = r_cval;
        end else if (i_cmd.wr_init) begin
            wdata = hearth ? i_cfg.hearth_temp : i_cfg.ambient_temp;
        end else if (i_cmd.wr_dst_avg) begin
            wdata = sum[ACC_W-1:2];
        end else begin
            wdata = src_data;
        end
    end

    jhs_ram #(.WIDTH(TEMP_W), .DEPTH(CELLS)) u_grid_first (
        .i_clk   (i_clk),
        .i_we    (we_first),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rd_first)
    );

    jhs_ram #(.WIDTH(TEMP_W), .DEPTH(CELLS)) u_grid_second (
        .i_clk   (i_clk),
        .i_we    (we_second),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rd_second)
    );

    // Command latch and sweep count
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op     <= t_op'(i_operation);
            r_crow   <= i_row;
            r_ccol   <= i_col;
            r_cval   <= i_cell_value;
            r_sweeps <= i_sweep_count;
        end else if (i_cmd.swap) begin
            r_sweeps <= r_sweeps - SWEEP_W'(1);
        end
    end

    // Cell walk counters
    always_ff @(posedge i_clk) begin
        if (i_cmd.cnt_clr) begin
            r_row <= '0;
            r_col <= '0;
        end else if (i_cmd.cnt_adv_full) begin
            r_col <= r_col + IDX_W'(1);
            if (r_col == IDX_LAST) begin
                r_row <= r_row + IDX_W'(1);
            end
        end else if (i_cmd.cnt_adv_len) begin
            if (r_col == len_m1) begin
                r_col <= '0;
                r_row <= r_row + IDX_W'(1);
            end else begin
                r_col <= r_col + IDX_W'(1);
            end
        end
    end

    // Neighbor accumulator
    always_ff @(posedge i_clk) begin
        if (i_cmd.acc_load) begin
            r_acc <= ACC_W'(src_data);
        end else if (i_cmd.acc_add) begin
            r_acc <= sum;
        end
    end

    // Result registers and current store flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd  <= '0;
            r_oor <= 1'b0;
            r_cur <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_rd  <= '0;
                r_oor <= 1'b0;
            end
            if (i_cmd.set_oor) begin
                r_oor <= 1'b1;
            end
            if (i_cmd.cap_rd) begin
                r_rd <= src_data;
            end
            if (i_cmd.clr_cur) begin
                r_cur <= 1'b0;
            end else if (i_cmd.swap) begin
                r_cur <= ~r_cur;
            end
        end
    end

    assign o_read_value   = r_rd;
    assign o_out_of_range = r_oor;

endmodule

FILE: rtl/jhs_ctrl.sv
// ============================================================================
// jhs_ctrl: command sequencer
// Decodes each item and steps the datapath through init, access and sweeps.
// ============================================================================
module jhs_ctrl
    import jhs_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd,
    output logic       o_busy,
    output logic       o_done
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and datapath commands
    always_comb begin
        n_state  = r_state;
        o_cmd    = '0;
        o_cmd.addr_sel = A_CNT;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                unique case (i_status.op)
                    OP_INIT: begin
                        o_cmd.cnt_clr = 1'b1;
                        n_state       = S_INIT;
                    end
                    OP_WRITE: begin
                        if (i_status.oor) begin
                            o_cmd.set_oor = 1'b1;
                        end else begin
                            o_cmd.wr_both = 1'b1;
                        end
                        n_state = S_DONE;
                    end
                    OP_READ: begin
                        if (i_status.oor) begin
                            o_cmd.set_oor = 1'b1;
                            n_state       = S_DONE;
                        end else begin
                            o_cmd.addr_sel = A_CMD;
                            n_state        = S_RDWAIT;
                        end
                    end
                    default: begin
                        o_cmd.cnt_clr = 1'b1;
                        if (i_status.sweeps_zero) begin
                            n_state = S_DONE;
                        end else if (i_status.len_zero) begin
                            n_state = S_SWAP;
                        end else begin
                            n_state = S_CELL;
                        end
                    end
                endcase
            end
            S_RDWAIT: begin
                o_cmd.cap_rd = 1'b1;
                n_state      = S_DONE;
            end
            S_INIT: begin
                o_cmd.wr_init = 1'b1;
                if (i_status.last_full) begin
                    o_cmd.clr_cur = 1'b1;
                    n_state       = S_DONE;
                end else begin
                    o_cmd.cnt_adv_full = 1'b1;
                end
            end
            S_CELL: begin
                if (i_status.border) begin
                    o_cmd.addr_sel = A_CNT;
                    n_state        = S_WB_C;
                end else begin
                    o_cmd.addr_sel = A_NORTH;
                    n_state        = S_RD_S;
                end
            end
            S_RD_S: begin
                o_cmd.addr_sel = A_SOUTH;
                o_cmd.acc_load = 1'b1;
                n_state        = S_RD_W;
            end
            S_RD_W: begin
                o_cmd.addr_sel = A_WEST;
                o_cmd.acc_add  = 1'b1;
                n_state        = S_RD_E;
            end
            S_RD_E: begin
                o_cmd.addr_sel = A_EAST;
                o_cmd.acc_add  = 1'b1;
                n_state        = S_WB;
            end
            S_WB, S_WB_C: begin
                o_cmd.wr_dst_avg  = (r_state == S_WB);
                o_cmd.wr_dst_copy = (r_state == S_WB_C);
                o_cmd.cnt_adv_len = 1'b1;
                n_state = i_status.last_cell ? S_SWAP : S_CELL;
            end
            S_SWAP: begin
                o_cmd.swap    = 1'b1;
                o_cmd.cnt_clr = 1'b1;
                if (i_status.sweeps_last) begin
                    n_state = S_DONE;
                end else if (i_status.len_zero) begin
                    n_state = S_SWAP;
                end else begin
                    n_state = S_CELL;
                end
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = (r_state == S_DONE);

    // An accepted item is decoded in the next cycle
    a_accept_decode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_start) |=> (r_state == S_DECODE))
        else $error("accepted item not decoded");

    // The result strobe lasts one cycle and frees the block
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) |=> (r_state == S_IDLE))
        else $error("done not followed by idle");

    // At most one write source drives the stores
    a_one_writer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.wr_both, o_cmd.wr_init, o_cmd.wr_dst_avg, o_cmd.wr_dst_copy}))
        else $error("conflicting store writes");

    // A swap only follows the last cell of a pass, another swap or the decode of a zero-length grid
    a_swap_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SWAP) |-> ($past(r_state) == S_WB || $past(r_state) == S_WB_C
                                 || $past(r_state) == S_SWAP
                                 || $past(r_state) == S_DECODE))
        else $error("swap out of order");

endmodule
